[src/ssm_pkg.sv]
// ssm_pkg: shared types and constants for the stop string matcher.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ssm_pkg;

   localparam int MAX_PATTERN_LEN = 8;
   localparam int NUM_PATTERNS    = 4;
   localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 4;
   localparam int POS_W           = $clog2(MAX_PATTERN_LEN);
   localparam int COUNT_W         = 32;
   localparam int INDEX_W         = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_A = 3'd0,
      CSR_PATTERN_B = 3'd1,
      CSR_PATTERN_C = 3'd2,
      CSR_PATTERN_D = 3'd3,
      CSR_LENGTH_A  = 3'd4,
      CSR_LENGTH_B  = 3'd5,
      CSR_LENGTH_C  = 3'd6,
      CSR_LENGTH_D  = 3'd7
   } csr_index_type;

   typedef logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0] pattern_type;

   typedef struct packed {
      logic                 matched;
      logic [COUNT_W-1:0]   match_offset;
      logic [INDEX_W-1:0]   match_index;
      logic                 cancel_requested;
      logic                 cancel_fire;
   } rsp_payload_type;

endpackage

[src/ssm_if.sv]
// Valid/ready channel interfaces for the stop string matcher.
// Depends on ssm_pkg for field widths.
`timescale 1ns / 1ps

interface ssm_req_if;
   logic                         valid;
   logic                         ready;
   logic [ssm_pkg::BYTE_W-1:0]   data_byte;
   logic                         chunk_last;
   logic                         cancel_poll;

   modport source (output valid, data_byte, chunk_last, cancel_poll, input ready);
   modport sink   (input valid, data_byte, chunk_last, cancel_poll, output ready);
endinterface

interface ssm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          matched;
   logic [ssm_pkg::COUNT_W-1:0]   match_offset;
   logic [ssm_pkg::INDEX_W-1:0]   match_index;
   logic                          cancel_requested;
   logic                          cancel_fire;

   modport source (output valid, matched, match_offset, match_index, cancel_requested,
                   cancel_fire, input ready);
   modport sink   (input valid, matched, match_offset, match_index, cancel_requested,
                   cancel_fire, output ready);
endinterface

[src/stop_string_matcher.sv]
// stop_string_matcher: byte-serial detector of up to four stop strings.
// Each rsp item is registered. Throughput: one byte per cycle while req is ready;
// the match and latch update for a byte is done in the cycle of its transfer.
// A two-entry output buffer keeps req ready while one result waits on rsp.
// Reset (synchronous, active high) clears patterns, lengths, count, latches and buffer.
// Depends on ssm_pkg and ssm_if.
`timescale 1ns / 1ps

module stop_string_matcher (
   input  logic                                clock,
   input  logic                                reset,
   ssm_req_if.sink                             req_bus,
   ssm_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_en,
   input  ssm_pkg::csr_index_type              csr_index,
   input  logic [ssm_pkg::CSR_DATA_W-1:0]      csr_data
);

   // configuration
   ssm_pkg::pattern_type                pattern_ff [ssm_pkg::NUM_PATTERNS];
   logic [ssm_pkg::LEN_W-1:0]           length_ff  [ssm_pkg::NUM_PATTERNS];

   // scan state
   logic [ssm_pkg::BYTE_W-1:0]          history_ff [ssm_pkg::HIST_DEPTH];
   logic [ssm_pkg::COUNT_W-1:0]         count_ff,   count_in;
   logic                                matched_ff, matched_in;
   logic [ssm_pkg::COUNT_W-1:0]         offset_ff,  offset_in;
   logic [ssm_pkg::INDEX_W-1:0]         index_ff,   index_in;
   logic                                cancel_ff,  cancel_in;
   logic                                fired_ff,   fired_in;

   // output buffer
   ssm_pkg::rsp_payload_type            out_ff, skid_ff, result;
   logic                                out_valid_ff, skid_valid_ff;

   logic                                accept, pop;
   logic [ssm_pkg::BYTE_W-1:0]          window [ssm_pkg::MAX_PATTERN_LEN];
   logic [ssm_pkg::NUM_PATTERNS-1:0]    hit;
   logic [ssm_pkg::LEN_W-1:0]           best_len;
   logic [ssm_pkg::INDEX_W-1:0]         best_idx;
   logic                                fire;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = out_valid_ff && rsp_bus.ready;

   // window[0] is the current byte, window[k] the byte k places earlier
   always_comb begin
      window[0] = req_bus.data_byte;
      for (int k = 1; k < ssm_pkg::MAX_PATTERN_LEN; k++) begin
         window[k] = history_ff[k-1];
      end
   end

   always_comb begin
      logic [ssm_pkg::LEN_W-1:0] len_m1;
      logic [ssm_pkg::LEN_W-1:0] pos;
      for (int p = 0; p < ssm_pkg::NUM_PATTERNS; p++) begin
         len_m1 = length_ff[p] - ssm_pkg::LEN_W'(1);
         hit[p] = (length_ff[p] != '0)
               && (length_ff[p] <= ssm_pkg::LEN_W'(ssm_pkg::MAX_PATTERN_LEN))
               && (count_ff >= ssm_pkg::COUNT_W'(len_m1));
         for (int k = 0; k < ssm_pkg::MAX_PATTERN_LEN; k++) begin
            pos = len_m1 - ssm_pkg::LEN_W'(k);
            if (ssm_pkg::LEN_W'(k) < length_ff[p]
                && pattern_ff[p][pos[ssm_pkg::POS_W-1:0]] != window[k]) begin
               hit[p] = 1'b0;
            end
         end
      end
   end

   // longest string wins, lowest index among equal lengths
   always_comb begin
      best_len = '0;
      best_idx = '0;
      for (int p = 0; p < ssm_pkg::NUM_PATTERNS; p++) begin
         if (hit[p] && length_ff[p] > best_len) begin
            best_len = length_ff[p];
            best_idx = ssm_pkg::INDEX_W'(p);
         end
      end
   end

   always_comb begin
      cancel_in  = cancel_ff;
      matched_in = matched_ff;
      offset_in  = offset_ff;
      index_in   = index_ff;
      fire       = 1'b0;
      if (req_bus.chunk_last && req_bus.cancel_poll) begin
         cancel_in = 1'b1;
         fire      = !cancel_ff && !fired_ff;
      end
      if (!matched_ff && best_len != '0) begin
         matched_in = 1'b1;
         index_in   = best_idx;
         offset_in  = count_ff - ssm_pkg::COUNT_W'(best_len - ssm_pkg::LEN_W'(1));
         fire       = fire || !fired_ff;
      end
      fired_in = fired_ff || fire;
      count_in = (&count_ff) ? count_ff : count_ff + ssm_pkg::COUNT_W'(1);

      result.matched          = matched_in;
      result.match_offset     = offset_in;
      result.match_index      = index_in;
      result.cancel_requested = cancel_in;
      result.cancel_fire      = fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < ssm_pkg::NUM_PATTERNS; p++) begin
            pattern_ff[p] <= '0;
            length_ff[p]  <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            ssm_pkg::CSR_PATTERN_A: pattern_ff[0] <= csr_data;
            ssm_pkg::CSR_PATTERN_B: pattern_ff[1] <= csr_data;
            ssm_pkg::CSR_PATTERN_C: pattern_ff[2] <= csr_data;
            ssm_pkg::CSR_PATTERN_D: pattern_ff[3] <= csr_data;
            ssm_pkg::CSR_LENGTH_A:  length_ff[0]  <= csr_data[ssm_pkg::LEN_W-1:0];
            ssm_pkg::CSR_LENGTH_B:  length_ff[1]  <= csr_data[ssm_pkg::LEN_W-1:0];
            ssm_pkg::CSR_LENGTH_C:  length_ff[2]  <= csr_data[ssm_pkg::LEN_W-1:0];
            ssm_pkg::CSR_LENGTH_D:  length_ff[3]  <= csr_data[ssm_pkg::LEN_W-1:0];
         endcase
      end
   end

   // history needs no reset: the byte count guards every read
   always_ff @(posedge clock) begin
      if (accept) begin
         history_ff[0] <= req_bus.data_byte;
         for (int k = 1; k < ssm_pkg::HIST_DEPTH; k++) begin
            history_ff[k] <= history_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         matched_ff <= 1'b0;
         offset_ff  <= '0;
         index_ff   <= '0;
         cancel_ff  <= 1'b0;
         fired_ff   <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         matched_ff <= matched_in;
         offset_ff  <= offset_in;
         index_ff   <= index_in;
         cancel_ff  <= cancel_in;
         fired_ff   <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.matched          = out_ff.matched;
   assign rsp_bus.match_offset     = out_ff.match_offset;
   assign rsp_bus.match_index      = out_ff.match_index;
   assign rsp_bus.cancel_requested = out_ff.cancel_requested;
   assign rsp_bus.cancel_fire      = out_ff.cancel_fire;

endmodule
